FILE: hdl/tsg_pkg.sv
// tsg_pkg: shared widths, codes, reset values and types for the trilinear sampler.
// Depends on nothing; the core, front, back and checker refer to it by scoped names.
`default_nettype none

package tsg_pkg;

   // fixed field widths
   localparam int POS_W   = 16;
   localparam int ADDR_W  = 18;
   localparam int INT_W   = 16;
   localparam int GRAD_W  = 24;
   localparam int OUT_W   = 24;
   localparam int CFG_W   = 7;
   localparam int CSR_IDX_W = 2;
   // stored voxel word: intensity, grad x, grad y, grad z
   localparam int WORD_W  = INT_W + 3 * GRAD_W;

   // parameter defaults
   localparam int VOXELS_DEF    = 262144;
   localparam int MAX_DIM_DEF   = 64;
   localparam int FRAC_BITS_DEF = 8;

   // request operation codes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 2'd2;

   localparam logic [CFG_W-1:0]  SIZE_RST  = 7'd64;
   localparam logic [GRAD_W-1:0] GRAD_BIAS = 24'h800000;

   // request control carried from front to back
   typedef struct packed {
      logic valid;
      logic sample;
      logic oob;
   } ctl_type;

endpackage

`default_nettype wire

FILE: hdl/trilinear_sample_with_gradient_core.sv
// Top level of the trilinear sampler: size registers, front, queue and back.
// Depends on tsg_pkg, tsg_front, tsg_queue and tsg_back.
//
//   channel   ports                      handshake
//   request   start/busy, req_*          taken when start & !busy
//   response  rsp_strobe, rsp_*          one cycle per result, no hold-off
//   config    csr_valid/csr_ready, csr_* written when valid & ready
//
// One request per cycle sustained while busy is low. A sample passes
// through 3 front stages, the queue, the store read and 3 blend stages;
// a voxel write returns nothing. The store needs no clearing after reset.
// Synchronous reset empties all stages; busy rises once queue entries plus
// front requests reach QD - 1. Store addresses wrap modulo VOXELS (a power of 2).
`default_nettype none

module trilinear_sample_with_gradient_core #(
   parameter int VOXELS    = tsg_pkg::VOXELS_DEF,
   parameter int MAX_DIM   = tsg_pkg::MAX_DIM_DEF,
   parameter int FRAC_BITS = tsg_pkg::FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_operation,
   input  wire logic [tsg_pkg::ADDR_W-1:0]        req_voxel_address,
   input  wire logic [tsg_pkg::INT_W-1:0]         req_intensity_in,
   input  wire logic signed [tsg_pkg::GRAD_W-1:0] req_grad_x_in,
   input  wire logic signed [tsg_pkg::GRAD_W-1:0] req_grad_y_in,
   input  wire logic signed [tsg_pkg::GRAD_W-1:0] req_grad_z_in,
   input  wire logic signed [tsg_pkg::POS_W-1:0]  req_pos_x,
   input  wire logic signed [tsg_pkg::POS_W-1:0]  req_pos_y,
   input  wire logic signed [tsg_pkg::POS_W-1:0]  req_pos_z,
   output logic                                   rsp_strobe,
   output logic                                   rsp_out_of_bounds,
   output logic [tsg_pkg::OUT_W-1:0]              rsp_intensity_out,
   output logic signed [tsg_pkg::GRAD_W-1:0]      rsp_grad_x_out,
   output logic signed [tsg_pkg::GRAD_W-1:0]      rsp_grad_y_out,
   output logic signed [tsg_pkg::GRAD_W-1:0]      rsp_grad_z_out,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [tsg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tsg_pkg::CFG_W-1:0]         csr_data
);

   localparam int AW    = $clog2(VOXELS);
   localparam int QD    = 8;
   localparam int QCW   = $clog2(QD + 1);
   localparam int QW    = 2 + 3 * FRAC_BITS + 8 * AW + tsg_pkg::WORD_W;

   // size registers
   logic [2:0][tsg_pkg::CFG_W-1:0] size_ff, size_in;
   always_comb begin
      size_in = size_ff;
      if (csr_valid) begin
         case (csr_index)
            tsg_pkg::CSR_SIZE_X: size_in[0] = csr_data;
            tsg_pkg::CSR_SIZE_Y: size_in[1] = csr_data;
            tsg_pkg::CSR_SIZE_Z: size_in[2] = csr_data;
            default:             size_in = size_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= {3{tsg_pkg::SIZE_RST}};
      end else begin
         size_ff <= size_in;
      end
   end

   assign csr_ready = 1'b1;

   // front
   logic                              accept;
   tsg_pkg::ctl_type                  f_ctl;
   logic [2:0][FRAC_BITS-1:0]         f_frac;
   logic [7:0][AW-1:0]                f_addr;
   logic [tsg_pkg::WORD_W-1:0]        f_wdata;
   logic [1:0]                        f_in_flight;

   assign accept = start && !busy;

   tsg_front #(
      .VOXELS(VOXELS), .MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .operation    (req_operation),
      .voxel_address(req_voxel_address),
      .wdata        ({req_intensity_in, req_grad_x_in, req_grad_y_in, req_grad_z_in}),
      .pos          ({req_pos_z, req_pos_y, req_pos_x}),
      .size         (size_ff),
      .out_ctl      (f_ctl),
      .out_frac     (f_frac),
      .out_addr     (f_addr),
      .out_wdata    (f_wdata),
      .in_flight    (f_in_flight)
   );

   // queue between front and back; back drains one entry per cycle
   logic [QW-1:0]  q_dout;
   logic           q_not_empty;
   logic [QCW-1:0] q_count;

   tsg_queue #(.W(QW), .DEPTH(QD)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_ctl.valid),
      .din      ({f_ctl.sample, f_ctl.oob, f_frac, f_addr, f_wdata}),
      .pop      (q_not_empty),
      .dout     (q_dout),
      .not_empty(q_not_empty),
      .count    (q_count)
   );

   // hold off requests only when the queue could overflow with stages in flight
   assign busy = (32'(q_count) + 32'(f_in_flight)) >= (QD - 1);

   // back
   tsg_pkg::ctl_type            b_ctl;
   logic [2:0][FRAC_BITS-1:0]   b_frac;
   logic [7:0][AW-1:0]          b_addr;
   logic [tsg_pkg::WORD_W-1:0]  b_wdata;

   always_comb begin
      {b_ctl.sample, b_ctl.oob, b_frac, b_addr, b_wdata} = q_dout;
      b_ctl.valid = q_not_empty;
   end

   tsg_back #(.VOXELS(VOXELS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .in_ctl           (b_ctl),
      .in_frac          (b_frac),
      .in_addr          (b_addr),
      .in_wdata         (b_wdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_of_bounds(rsp_out_of_bounds),
      .rsp_intensity_out(rsp_intensity_out),
      .rsp_grad_x_out   (rsp_grad_x_out),
      .rsp_grad_y_out   (rsp_grad_y_out),
      .rsp_grad_z_out   (rsp_grad_z_out)
   );

endmodule

`default_nettype wire

FILE: hdl/tsg_front.sv
// tsg_front: accepts requests, splits positions, flags out of bounds and
// builds the eight corner addresses in three stages. Depends on tsg_pkg.
`default_nettype none

module tsg_front #(
   parameter int VOXELS    = tsg_pkg::VOXELS_DEF,
   parameter int MAX_DIM   = tsg_pkg::MAX_DIM_DEF,
   parameter int FRAC_BITS = tsg_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  accept,
   input  wire logic                                  operation,
   input  wire logic [tsg_pkg::ADDR_W-1:0]            voxel_address,
   input  wire logic [tsg_pkg::WORD_W-1:0]            wdata,
   input  wire logic [2:0][tsg_pkg::POS_W-1:0]        pos,
   input  wire logic [2:0][tsg_pkg::CFG_W-1:0]        size,
   output tsg_pkg::ctl_type                           out_ctl,
   output logic [2:0][FRAC_BITS-1:0]                  out_frac,
   output logic [7:0][$clog2(VOXELS)-1:0]             out_addr,
   output logic [tsg_pkg::WORD_W-1:0]                 out_wdata,
   output logic [1:0]                                 in_flight
);

   localparam int AW = $clog2(VOXELS);
   localparam int CW = $clog2(MAX_DIM);
   localparam int YW = 2 * CW;
   localparam int LW = 3 * CW;
   localparam int SW = $clog2(MAX_DIM + 1);

   // effective sizes, clamped to MAX_DIM
   logic [2:0][SW-1:0] eff;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (32'(size[k]) > MAX_DIM) begin
            eff[k] = SW'(MAX_DIM);
         end else begin
            eff[k] = SW'(size[k]);
         end
      end
   end

   // stage 1: floor, fraction, bounds
   tsg_pkg::ctl_type              s1_ctl_ff, s1_ctl_in;
   logic [2:0][CW-1:0]            s1_fl_ff, s1_fl_in;
   logic [2:0][FRAC_BITS-1:0]     s1_fr_ff, s1_fr_in;
   logic [AW-1:0]                 s1_wa_ff;
   logic [tsg_pkg::WORD_W-1:0]    s1_wd_ff;

   always_comb begin
      logic signed [tsg_pkg::POS_W:0] fl_s;
      logic                           oob;
      oob = 1'b0;
      for (int k = 0; k < 3; k++) begin
         fl_s = (tsg_pkg::POS_W + 1)'($signed(pos[k]) >>> FRAC_BITS);
         s1_fl_in[k] = fl_s[CW-1:0];
         s1_fr_in[k] = pos[k][FRAC_BITS-1:0];
         if (fl_s[tsg_pkg::POS_W] ||
             ((fl_s[tsg_pkg::POS_W-1:0] + 16'd1) >= 16'(eff[k]))) begin
            oob = 1'b1;
         end
      end
      s1_ctl_in.valid  = accept;
      s1_ctl_in.sample = (operation == tsg_pkg::OP_SAMPLE);
      s1_ctl_in.oob    = oob;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= s1_ctl_in;
      end
      s1_fl_ff <= s1_fl_in;
      s1_fr_ff <= s1_fr_in;
      s1_wa_ff <= AW'(voxel_address);
      s1_wd_ff <= wdata;
   end

   // stage 2: y + size_y * z for the four y/z corner pairs
   tsg_pkg::ctl_type              s2_ctl_ff;
   logic [3:0][YW-1:0]            s2_yz_ff, s2_yz_in;
   logic [CW-1:0]                 s2_fx_ff;
   logic [2:0][FRAC_BITS-1:0]     s2_fr_ff;
   logic [AW-1:0]                 s2_wa_ff;
   logic [tsg_pkg::WORD_W-1:0]    s2_wd_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         s2_yz_in[j] = YW'(s1_fl_ff[1]) + YW'(j & 1)
                     + YW'(eff[1]) * (YW'(s1_fl_ff[2]) + YW'(j >> 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else begin
         s2_ctl_ff <= s1_ctl_ff;
      end
      s2_yz_ff <= s2_yz_in;
      s2_fx_ff <= s1_fl_ff[0];
      s2_fr_ff <= s1_fr_ff;
      s2_wa_ff <= s1_wa_ff;
      s2_wd_ff <= s1_wd_ff;
   end

   // stage 3: x + size_x * yz, wrapped to the store; writes use corner 0
   tsg_pkg::ctl_type              s3_ctl_ff;
   logic [7:0][AW-1:0]            s3_addr_ff, s3_addr_in;
   logic [2:0][FRAC_BITS-1:0]     s3_fr_ff;
   logic [tsg_pkg::WORD_W-1:0]    s3_wd_ff;

   always_comb begin
      logic [LW-1:0] lin;
      for (int k = 0; k < 8; k++) begin
         lin = LW'(s2_fx_ff) + LW'(k & 1)
             + LW'(eff[0]) * LW'(s2_yz_ff[k >> 1]);
         s3_addr_in[k] = AW'(lin);
      end
      if (!s2_ctl_ff.sample) begin
         s3_addr_in[0] = s2_wa_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else begin
         s3_ctl_ff <= s2_ctl_ff;
      end
      s3_addr_ff <= s3_addr_in;
      s3_fr_ff   <= s2_fr_ff;
      s3_wd_ff   <= s2_wd_ff;
   end

   assign out_ctl   = s3_ctl_ff;
   assign out_frac  = s3_fr_ff;
   assign out_addr  = s3_addr_ff;
   assign out_wdata = s3_wd_ff;
   assign in_flight = 2'(s1_ctl_ff.valid) + 2'(s2_ctl_ff.valid) + 2'(s3_ctl_ff.valid);

endmodule

`default_nettype wire

FILE: hdl/tsg_queue.sv
// tsg_queue: small first-in first-out queue between front and back.
// Depends on nothing beyond its parameters.
`default_nettype none

module tsg_queue #(
   parameter int W     = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire logic [W-1:0]                 din,
   input  wire logic                         pop,
   output logic [W-1:0]                      dout,
   output logic                              not_empty,
   output logic [$clog2(DEPTH+1)-1:0]        count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CNW = $clog2(DEPTH + 1);

   logic [W-1:0]   slot_ff [DEPTH];
   logic [PW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic           do_pop;

   assign do_pop = pop && (cnt_ff != '0);

   // pointer and fill bookkeeping
   always_comb begin
      wr_in  = push ? PW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? PW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = CNW'(cnt_ff + CNW'(push) - CNW'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= din;
      end
   end

   assign dout      = slot_ff[rd_ff];
   assign not_empty = (cnt_ff != '0);
   assign count     = cnt_ff;

endmodule

`default_nettype wire

FILE: hdl/tsg_back.sv
// tsg_back: voxel store (eight copies, one per corner) and the x, y, z blend
// stages with the result register. Depends on tsg_pkg.
`default_nettype none

module tsg_back #(
   parameter int VOXELS    = tsg_pkg::VOXELS_DEF,
   parameter int FRAC_BITS = tsg_pkg::FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire tsg_pkg::ctl_type                   in_ctl,
   input  wire logic [2:0][FRAC_BITS-1:0]          in_frac,
   input  wire logic [7:0][$clog2(VOXELS)-1:0]     in_addr,
   input  wire logic [tsg_pkg::WORD_W-1:0]         in_wdata,
   output logic                                    rsp_strobe,
   output logic                                    rsp_out_of_bounds,
   output logic [tsg_pkg::OUT_W-1:0]               rsp_intensity_out,
   output logic [tsg_pkg::GRAD_W-1:0]              rsp_grad_x_out,
   output logic [tsg_pkg::GRAD_W-1:0]              rsp_grad_y_out,
   output logic [tsg_pkg::GRAD_W-1:0]              rsp_grad_z_out
);

   localparam int AW = $clog2(VOXELS);
   localparam int VW = tsg_pkg::OUT_W;
   localparam int BW = VW + FRAC_BITS + 2;
   localparam logic [FRAC_BITS:0] ONE  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
   localparam logic [BW-1:0]      HALF = BW'(1) << (FRAC_BITS - 1);

   // (a*(1-f) + b*f + half) >> F, rounding half up
   function automatic logic [VW-1:0] blend(input logic [VW-1:0] a,
                                           input logic [VW-1:0] b,
                                           input logic [FRAC_BITS-1:0] f);
      logic [BW-1:0] s;
      s = BW'(a) * BW'(ONE - (FRAC_BITS + 1)'(f)) + BW'(b) * BW'(f) + HALF;
      return s[FRAC_BITS +: VW];
   endfunction

   // voxel store: a write goes to every copy, each corner reads its own copy
   logic [7:0][tsg_pkg::WORD_W-1:0] rd_ff;
   logic                            wr_en;
   assign wr_en = in_ctl.valid && !in_ctl.sample;

   for (genvar c = 0; c < 8; c++) begin : g_copy
      logic [tsg_pkg::WORD_W-1:0] mem [VOXELS];
      always_ff @(posedge clock) begin
         if (wr_en) begin
            mem[in_addr[0]] <= in_wdata;
         end
         rd_ff[c] <= mem[in_addr[c]];
      end
   end

   // read stage control
   tsg_pkg::ctl_type          r_ctl_ff, r_ctl_in;
   logic [2:0][FRAC_BITS-1:0] r_fr_ff;

   always_comb begin
      r_ctl_in        = in_ctl;
      r_ctl_in.valid  = in_ctl.valid && in_ctl.sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ctl_ff <= '0;
      end else begin
         r_ctl_ff <= r_ctl_in;
      end
      r_fr_ff <= in_frac;
   end

   // corner values per channel: intensity scaled, gradients offset binary
   logic [3:0][7:0][VW-1:0] corner;
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         corner[0][k] = {rd_ff[k][tsg_pkg::WORD_W-1 -: tsg_pkg::INT_W], 8'h00};
         corner[1][k] = rd_ff[k][3*tsg_pkg::GRAD_W-1 -: tsg_pkg::GRAD_W] ^ tsg_pkg::GRAD_BIAS;
         corner[2][k] = rd_ff[k][2*tsg_pkg::GRAD_W-1 -: tsg_pkg::GRAD_W] ^ tsg_pkg::GRAD_BIAS;
         corner[3][k] = rd_ff[k][tsg_pkg::GRAD_W-1:0] ^ tsg_pkg::GRAD_BIAS;
      end
   end

   // x blends
   tsg_pkg::ctl_type          x_ctl_ff;
   logic [1:0][FRAC_BITS-1:0] x_fr_ff;
   logic [3:0][3:0][VW-1:0]   x_ff, x_in;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            x_in[c][i] = blend(corner[c][2*i], corner[c][2*i+1], r_fr_ff[0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ctl_ff <= '0;
      end else begin
         x_ctl_ff <= r_ctl_ff;
      end
      x_ff    <= x_in;
      x_fr_ff <= r_fr_ff[2:1];
   end

   // y blends
   tsg_pkg::ctl_type        y_ctl_ff;
   logic [FRAC_BITS-1:0]    y_fr_ff;
   logic [3:0][1:0][VW-1:0] y_ff, y_in;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 2; i++) begin
            y_in[c][i] = blend(x_ff[c][2*i], x_ff[c][2*i+1], x_fr_ff[0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_ctl_ff <= '0;
      end else begin
         y_ctl_ff <= x_ctl_ff;
      end
      y_ff    <= y_in;
      y_fr_ff <= x_fr_ff[1];
   end

   // z blend and result register; out of bounds forces zeros
   logic                 o_strobe_ff;
   logic                 o_oob_ff;
   logic [3:0][VW-1:0]   o_val_ff, o_val_in;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         o_val_in[c] = blend(y_ff[c][0], y_ff[c][1], y_fr_ff);
         if (c != 0) begin
            o_val_in[c] = o_val_in[c] ^ tsg_pkg::GRAD_BIAS;
         end
         if (y_ctl_ff.oob) begin
            o_val_in[c] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_strobe_ff <= 1'b0;
      end else begin
         o_strobe_ff <= y_ctl_ff.valid;
      end
      o_oob_ff <= y_ctl_ff.oob;
      o_val_ff <= o_val_in;
   end

   assign rsp_strobe        = o_strobe_ff;
   assign rsp_out_of_bounds = o_oob_ff;
   assign rsp_intensity_out = o_val_ff[0];
   assign rsp_grad_x_out    = o_val_ff[1];
   assign rsp_grad_y_out    = o_val_ff[2];
   assign rsp_grad_z_out    = o_val_ff[3];

endmodule

`default_nettype wire

FILE: hdl/tsg_checker.sv
// tsg_checker: port-level checks of the trilinear sampler, bound to its top.
// Depends on tsg_pkg and trilinear_sample_with_gradient_core.
`default_nettype none

module tsg_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic                         req_operation,
   input wire logic                         rsp_strobe,
   input wire logic                         rsp_out_of_bounds,
   input wire logic [tsg_pkg::OUT_W-1:0]    rsp_intensity_out,
   input wire logic [tsg_pkg::GRAD_W-1:0]   rsp_grad_x_out,
   input wire logic [tsg_pkg::GRAD_W-1:0]   rsp_grad_y_out,
   input wire logic [tsg_pkg::GRAD_W-1:0]   rsp_grad_z_out
);

   // every response traces back to a request that was taken
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 8))
      else $error("response without matching request");

   // a voxel write produces no response where a sample's result would appear
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == tsg_pkg::OP_WRITE) |-> ##8 !rsp_strobe)
      else $error("response from a voxel write");

   // out of bounds results carry zeros
   a_oob_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_out_of_bounds) |->
         (rsp_intensity_out == '0 && rsp_grad_x_out == '0 &&
          rsp_grad_y_out == '0 && rsp_grad_z_out == '0))
      else $error("out of bounds result not zero");

   // reset empties the pipeline
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("response right after reset");

endmodule

bind trilinear_sample_with_gradient_core tsg_checker u_tsg_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_operation    (req_operation),
   .rsp_strobe       (rsp_strobe),
   .rsp_out_of_bounds(rsp_out_of_bounds),
   .rsp_intensity_out(rsp_intensity_out),
   .rsp_grad_x_out   (rsp_grad_x_out),
   .rsp_grad_y_out   (rsp_grad_y_out),
   .rsp_grad_z_out   (rsp_grad_z_out)
);

`default_nettype wire
